/* sv/lmbe_pkg.sv */
// Shared types, constants and gamma table for the LED matrix bit-plane encoder.
// No dependencies.
package lmbe_pkg;

   localparam int DEFAULT_HALF_HEIGHT = 16;
   localparam int ROW_WIDTH           = 4;
   localparam int PIXEL_WIDTH         = 15;
   localparam int CHAN_WIDTH          = 5;
   localparam int LEVEL_WIDTH         = 8;
   localparam int PLANE_COUNT         = 8;
   localparam int PLANE_WIDTH         = 3;
   localparam int WORD_WIDTH          = 13;
   localparam int CHANNELS            = 6;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_LATCH = 1'b1;

   localparam int STROBE_POS     = 4;
   localparam int ENABLE_POS     = 5;
   localparam int TOP_RGB_POS    = 6;
   localparam int BOTTOM_RGB_POS = 10;

   localparam logic [PLANE_WIDTH-1:0] LAST_PLANE = PLANE_WIDTH'(PLANE_COUNT - 1);

   localparam logic [LEVEL_WIDTH-1:0] GAMMA_LUT [32] = '{
        8'd0,   8'd0,   8'd1,   8'd2,   8'd3,   8'd5,   8'd7,  8'd10,
       8'd13,  8'd17,  8'd21,  8'd26,  8'd32,  8'd38,  8'd44,  8'd52,
       8'd60,  8'd68,  8'd77,  8'd87,  8'd97, 8'd108, 8'd120, 8'd132,
      8'd145, 8'd159, 8'd173, 8'd188, 8'd204, 8'd220, 8'd237, 8'd255
   };

   // levels: top red, green, blue, then bottom red, green, blue
   typedef struct packed {
      logic                                   mode;
      logic [ROW_WIDTH-1:0]                   row_address;
      logic [CHANNELS-1:0][LEVEL_WIDTH-1:0]   levels;
   } entry_type;

endpackage

/* sv/lmbe_req_if.sv */
// Request channel: pixel pair or row-end latch, valid/ready handshake.
// Depends on lmbe_pkg.
interface lmbe_req_if;
   import lmbe_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   mode;
   logic [ROW_WIDTH-1:0]   row_address;
   logic [PIXEL_WIDTH-1:0] top_pixel;
   logic [PIXEL_WIDTH-1:0] bottom_pixel;

   modport source (output valid, mode, row_address, top_pixel, bottom_pixel, input ready);
   modport sink   (input valid, mode, row_address, top_pixel, bottom_pixel, output ready);
endinterface

/* sv/lmbe_rsp_if.sv */
// Response channel: one panel port word per bit plane, valid/ready handshake.
// Depends on lmbe_pkg.
interface lmbe_rsp_if;
   import lmbe_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [PLANE_WIDTH-1:0] plane;
   logic [WORD_WIDTH-1:0]  port_word;
   logic                   last;

   modport source (output valid, plane, port_word, last, input ready);
   modport sink   (input valid, plane, port_word, last, output ready);
endinterface

/* sv/lmbe_front.sv */
// Front end: accepts requests, saturates the row address and gamma-corrects channels.
// Depends on lmbe_pkg and lmbe_req_if.
module lmbe_front #(
   parameter int HALF_HEIGHT = lmbe_pkg::DEFAULT_HALF_HEIGHT
) (
   lmbe_req_if.sink              req,
   input  logic                  queue_ready,
   output logic                  push,
   output lmbe_pkg::entry_type   entry
);
   import lmbe_pkg::*;

   localparam logic [ROW_WIDTH-1:0] MAX_ROW = ROW_WIDTH'(HALF_HEIGHT - 1);

   assign req.ready = queue_ready;
   assign push      = req.valid && queue_ready;

   always_comb begin
      entry.mode        = req.mode;
      entry.row_address = (req.row_address > MAX_ROW) ? MAX_ROW : req.row_address;
      for (int i = 0; i < 3; i++) begin
         entry.levels[i]   = GAMMA_LUT[req.top_pixel[(2 - i) * CHAN_WIDTH +: CHAN_WIDTH]];
         entry.levels[3+i] = GAMMA_LUT[req.bottom_pixel[(2 - i) * CHAN_WIDTH +: CHAN_WIDTH]];
      end
   end

endmodule

/* sv/lmbe_queue.sv */
// Two-entry queue between front and back end.
// Depends on lmbe_pkg.
module lmbe_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lmbe_pkg::entry_type   push_entry,
   output logic                  push_ready,
   input  logic                  pop,
   output logic                  pop_valid,
   output lmbe_pkg::entry_type   pop_entry
);
   import lmbe_pkg::*;

   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(QUEUE_DEPTH);

   entry_type              entries_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> push_ready)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> pop_valid)
      else $error("pop from empty queue");

endmodule

/* sv/lmbe_back.sv */
// Back end: walks the eight bit planes of one entry into a registered port word.
// Depends on lmbe_pkg and lmbe_rsp_if.
module lmbe_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  entry_valid,
   input  lmbe_pkg::entry_type   entry,
   output logic                  pop,
   lmbe_rsp_if.source            rsp
);
   import lmbe_pkg::*;

   entry_type              cur_ff, cur_in;
   logic                   cur_valid_ff, cur_valid_in;
   logic [PLANE_WIDTH-1:0] plane_ff, plane_in;
   logic                   out_valid_ff, out_valid_in;
   logic [PLANE_WIDTH-1:0] out_plane_ff, out_plane_in;
   logic [WORD_WIDTH-1:0]  out_word_ff, out_word_in;
   logic                   out_last_ff, out_last_in;

   logic                   advance;
   logic                   finishing;
   logic [WORD_WIDTH-1:0]  word;

   assign advance   = cur_valid_ff && (!out_valid_ff || rsp.ready);
   assign finishing = advance && (plane_ff == LAST_PLANE);
   assign pop       = entry_valid && (!cur_valid_ff || finishing);

   always_comb begin
      word = '0;
      if (cur_ff.mode == MODE_LATCH) begin
         word[STROBE_POS] = 1'b1;
      end else begin
         word[ROW_WIDTH-1:0] = cur_ff.row_address;
         word[ENABLE_POS]    = 1'b1;
         for (int i = 0; i < 3; i++) begin
            word[TOP_RGB_POS + i]    = cur_ff.levels[i][plane_ff];
            word[BOTTOM_RGB_POS + i] = cur_ff.levels[3+i][plane_ff];
         end
      end
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      plane_in     = plane_ff;
      out_valid_in = out_valid_ff;
      out_plane_in = out_plane_ff;
      out_word_in  = out_word_ff;
      out_last_in  = out_last_ff;
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_plane_in = plane_ff;
         out_word_in  = word;
         out_last_in  = (plane_ff == LAST_PLANE);
         plane_in     = plane_ff + 1'b1;
         if (finishing) begin
            cur_valid_in = 1'b0;
         end
      end
      if (pop) begin
         cur_in       = entry;
         cur_valid_in = 1'b1;
         plane_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      out_plane_ff <= out_plane_in;
      out_word_ff  <= out_word_in;
      out_last_ff  <= out_last_in;
      if (reset) begin
         cur_valid_ff <= 1'b0;
         plane_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         plane_ff     <= plane_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.plane     = out_plane_ff;
   assign rsp.port_word = out_word_ff;
   assign rsp.last      = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (plane_ff != '0) |-> cur_valid_ff)
      else $error("plane counter running without an entry");
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_last_ff == (out_plane_ff == LAST_PLANE)))
      else $error("last flag out of step with plane");
   assert property (@(posedge clock) disable iff (reset)
      (advance && (plane_ff != LAST_PLANE)) |=> (cur_valid_ff && plane_ff == $past(plane_ff) + 1'b1))
      else $error("plane sequence broken");

endmodule

/* sv/led_matrix_bitplane_encoder.sv */
// Top level of the LED matrix bit-plane encoder: front end, queue and back end.
// Depends on lmbe_pkg, lmbe_req_if, lmbe_rsp_if, lmbe_front, lmbe_queue, lmbe_back.
//
// Each accepted request, pixel pair or row-end latch, yields eight port words, planes 0
// to 7, in order while the response side is ready; the plane counter of the back end
// steps through them. A request passes through the queue, the current-entry register
// and the output register before its first word is offered. A two-entry queue lets requests be
// taken while the back end is still emitting, and the response is driven from registers.
module led_matrix_bitplane_encoder #(
   parameter int HALF_HEIGHT = lmbe_pkg::DEFAULT_HALF_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   lmbe_req_if.sink    req,
   lmbe_rsp_if.source  rsp
);
   import lmbe_pkg::*;

   logic      push;
   logic      push_ready;
   entry_type push_entry;
   logic      pop;
   logic      pop_valid;
   entry_type pop_entry;

   lmbe_front #(
      .HALF_HEIGHT(HALF_HEIGHT)
   ) u_front (
      .req         (req),
      .queue_ready (push_ready),
      .push        (push),
      .entry       (push_entry)
   );

   lmbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   lmbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (pop_valid),
      .entry       (pop_entry),
      .pop         (pop),
      .rsp         (rsp)
   );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench for led_matrix_bitplane_encoder: pixel pairs and row-end latches go in,
// eight port words per request are predicted and checked. Depends on lmbe_pkg,
// lmbe_req_if, lmbe_rsp_if and the encoder RTL.
module tb;
   import lmbe_pkg::*;

   localparam int HALF_HEIGHT   = DEFAULT_HALF_HEIGHT;
   localparam int CLOCK_PERIOD  = 12;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int RANDOM_ITEMS  = 200;
   localparam int SETTLE_CYCLES = 16;

   localparam int STROBE_BIT_POS = 4;
   localparam int ENABLE_BIT_POS = 5;
   localparam int TOP_BITS_POS   = 6;
   localparam int BOT_BITS_POS   = 10;

   localparam logic [7:0] BRIGHTNESS [32] = '{
        8'd0,   8'd0,   8'd1,   8'd2,   8'd3,   8'd5,   8'd7,  8'd10,
       8'd13,  8'd17,  8'd21,  8'd26,  8'd32,  8'd38,  8'd44,  8'd52,
       8'd60,  8'd68,  8'd77,  8'd87,  8'd97, 8'd108, 8'd120, 8'd132,
      8'd145, 8'd159, 8'd173, 8'd188, 8'd204, 8'd220, 8'd237, 8'd255
   };

   typedef struct packed {
      logic                   mode;
      logic [ROW_WIDTH-1:0]   row_address;
      logic [PIXEL_WIDTH-1:0] top_pixel;
      logic [PIXEL_WIDTH-1:0] bottom_pixel;
   } pixel_request_type;

   typedef struct packed {
      logic [PLANE_WIDTH-1:0] plane;
      logic [WORD_WIDTH-1:0]  port_word;
      logic                   last;
   } plane_word_type;

   logic clock;
   logic reset;

   lmbe_req_if req_if ();
   lmbe_rsp_if rsp_if ();

   plane_word_type expected_words [$];
   int             fail_count;
   int             cycle_count;
   bit             sender_steady;
   bit             receiver_steady;

   led_matrix_bitplane_encoder #(
      .HALF_HEIGHT(HALF_HEIGHT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_if.sink),
      .rsp  (rsp_if.source)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** led_matrix_bitplane_encoder: FAILED **");
      $finish;
   end

   function automatic void predict_port_words(input pixel_request_type r);
      logic [ROW_WIDTH-1:0]  addr;
      logic [7:0]            level [6];
      logic [WORD_WIDTH-1:0] w;
      plane_word_type        e;
      addr = (int'(r.row_address) > HALF_HEIGHT - 1) ? ROW_WIDTH'(HALF_HEIGHT - 1)
                                                      : r.row_address;
      level[0] = BRIGHTNESS[r.top_pixel[14:10]];
      level[1] = BRIGHTNESS[r.top_pixel[9:5]];
      level[2] = BRIGHTNESS[r.top_pixel[4:0]];
      level[3] = BRIGHTNESS[r.bottom_pixel[14:10]];
      level[4] = BRIGHTNESS[r.bottom_pixel[9:5]];
      level[5] = BRIGHTNESS[r.bottom_pixel[4:0]];
      for (int p = 0; p < PLANE_COUNT; p++) begin
         w = '0;
         if (r.mode == MODE_LATCH) begin
            w[STROBE_BIT_POS] = 1'b1;
         end else begin
            w[ROW_WIDTH-1:0] = addr;
            w[ENABLE_BIT_POS] = 1'b1;
            for (int c = 0; c < 3; c++) begin
               w[TOP_BITS_POS + c] = level[c][p];
               w[BOT_BITS_POS + c] = level[3 + c][p];
            end
         end
         e.plane     = PLANE_WIDTH'(p);
         e.port_word = w;
         e.last      = (p == PLANE_COUNT - 1);
         expected_words.push_back(e);
      end
   endfunction

   task automatic send_request(input pixel_request_type r);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
      @(negedge clock);
      req_if.valid        = 1'b1;
      req_if.mode         = r.mode;
      req_if.row_address  = r.row_address;
      req_if.top_pixel    = r.top_pixel;
      req_if.bottom_pixel = r.bottom_pixel;
      do @(posedge clock); while (!req_if.ready);
      predict_port_words(r);
   endtask

   task automatic send_pixels(input logic [3:0] row, input logic [14:0] top,
                              input logic [14:0] bottom);
      send_request('{MODE_PIXEL, row, top, bottom});
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // receive side: random stall per word unless steady, then check the transfer
   initial begin
      int             stall;
      plane_word_type e;
      rsp_if.ready = 1'b0;
      wait (!reset);
      forever begin
         stall = receiver_steady ? 0 : $urandom_range(0, 8);
         repeat (stall) begin
            @(negedge clock);
            rsp_if.ready = 1'b0;
         end
         @(negedge clock);
         rsp_if.ready = 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         if (expected_words.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected word plane=%0d port_word=%h last=%b", $time,
                     rsp_if.plane, rsp_if.port_word, rsp_if.last);
         end else begin
            e = expected_words.pop_front();
            if (rsp_if.plane !== e.plane) begin
               fail_count++;
               $display("%0t: plane expected %0d actual %0d", $time, e.plane,
                        rsp_if.plane);
            end
            if (rsp_if.port_word !== e.port_word) begin
               fail_count++;
               $display("%0t: port_word expected %h actual %h (plane %0d)", $time,
                        e.port_word, rsp_if.port_word, e.plane);
            end
            if (rsp_if.last !== e.last) begin
               fail_count++;
               $display("%0t: last expected %b actual %b (plane %0d)", $time, e.last,
                        rsp_if.last, e.plane);
            end
         end
      end
   end

   task automatic test_extremes();
      send_pixels(4'd0, 15'h0000, 15'h0000);
      send_pixels(4'd15, 15'h7fff, 15'h7fff);
      for (int c = 0; c < 3; c++) begin
         send_pixels(4'(c), 15'h1f << (10 - 5 * c), 15'h0000);
         send_pixels(4'(c + 8), 15'h0000, 15'h1f << (10 - 5 * c));
      end
      send_pixels(4'ha, 15'h5555, 15'h2aaa);
      send_pixels(4'h5, 15'h2aaa, 15'h5555);
   endtask

   // every gamma entry lands on some channel
   task automatic test_gamma_sweep();
      logic [4:0] v [6];
      for (int k = 0; k < 6; k++) begin
         for (int c = 0; c < 6; c++) v[c] = 5'(k * 6 + c);
         send_pixels(4'(k + 3), {v[0], v[1], v[2]}, {v[3], v[4], v[5]});
      end
   endtask

   task automatic test_latch();
      sender_steady = 1'b1;
      send_request('{MODE_LATCH, 4'h0, 15'h0000, 15'h0000});
      send_request('{MODE_LATCH, 4'hf, 15'h7fff, 15'h7fff});
      send_pixels(4'h7, 15'h4210, 15'h7c1f);
      send_request('{MODE_LATCH, 4'h9, 15'h1234, 15'h4321});
      sender_steady = 1'b0;
   endtask

   task automatic test_random();
      pixel_request_type r;
      int                style;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 20 == 0) begin
            style           = $urandom_range(0, 3);
            sender_steady   = (style == 0) || (style == 1);
            receiver_steady = (style == 0) || (style == 2);
         end
         if (n == RANDOM_ITEMS / 2) wait_until_drained();
         r.mode         = ($urandom_range(0, 6) == 0) ? MODE_LATCH : MODE_PIXEL;
         r.row_address  = ROW_WIDTH'($urandom_range(0, 15));
         r.top_pixel    = PIXEL_WIDTH'($urandom_range(0, 32767));
         r.bottom_pixel = PIXEL_WIDTH'($urandom_range(0, 32767));
         send_request(r);
      end
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
   endtask

   initial begin
      fail_count          = 0;
      sender_steady       = 1'b0;
      receiver_steady     = 1'b0;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.mode         = MODE_PIXEL;
      req_if.row_address  = '0;
      req_if.top_pixel    = '0;
      req_if.bottom_pixel = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_gamma_sweep();
      test_latch();
      test_random();

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("** led_matrix_bitplane_encoder: PASSED **");
      end else begin
         $display("** led_matrix_bitplane_encoder: FAILED **");
      end
      $finish;
   end

endmodule
